// ===== hdl/tcld_pkg.sv =====
// Shared types, constants and helpers for the two-choice load dispatcher.
// Used by the front, queue and back modules and by the top level.
package tcld_pkg;

  localparam int NUM_LOADS       = 8;
  localparam int LOAD_W          = 32;
  localparam int WORKER_W        = 3;
  localparam int COUNT_W         = 4;
  localparam int TICKET_W        = 64;
  localparam int CFG_INDEX_W     = 1;
  localparam int CFG_DATA_W      = 64;
  localparam int MAX_WORKERS_DEF = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_WORKER_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_SEED = 1'd1;

  localparam logic [TICKET_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [TICKET_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [TICKET_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;
  localparam int MIX_SHIFT_0 = 30;
  localparam int MIX_SHIFT_1 = 27;
  localparam int MIX_SHIFT_2 = 31;

  // How a request was classified by the front
  localparam logic [1:0] KIND_SINGLE  = 2'd0;
  localparam logic [1:0] KIND_ROUND   = 2'd1;
  localparam logic [1:0] KIND_BALANCE = 2'd2;

  typedef logic [NUM_LOADS-1:0][LOAD_W-1:0] tcld_loads_t;

  typedef struct packed {
    tcld_loads_t               loads;
    logic [WORKER_W-1:0]       first;
    logic [COUNT_W-1:0]        count;
    logic [1:0]                kind;
    logic [TICKET_W-1:0]       hash;
  } tcld_job_t;

  // One byte of restoring remainder: rem < n, result < n, n in 2..8
  function automatic logic [WORKER_W-1:0] mod_step8(input logic [WORKER_W-1:0] rem,
                                                   input logic [7:0] digit,
                                                   input logic [COUNT_W-1:0] n);
    logic [COUNT_W:0] r;
    r = {2'b00, rem};
    for (int i = 7; i >= 0; i--) begin
      r = {r[COUNT_W-1:0], digit[i]};
      if (r >= {1'b0, n}) begin
        r = r - {1'b0, n};
      end
    end
    return r[WORKER_W-1:0];
  endfunction

endpackage

// ===== hdl/tcld_front.sv =====
// Front end: accepts requests, holds configuration, ticket and seed,
// classifies each request and works out its first pick (round-robin or ticket mod count).
// Depends on tcld_pkg.
module tcld_front #(
  parameter int MAX_WORKERS = tcld_pkg::MAX_WORKERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tcld_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tcld_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tcld_pkg::tcld_loads_t             in_loads,
  output logic                              push_valid,
  input  logic                              push_ready,
  output tcld_pkg::tcld_job_t               push_data
);
  import tcld_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MOD  = 3'd1;
  localparam logic [2:0] F_PUSH = 3'd2;

  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_WORKERS);

  logic [2:0]          fstate;
  logic [COUNT_W-1:0]  worker_count;
  logic [TICKET_W-1:0] ticket_counter;
  logic [TICKET_W-1:0] running_seed;
  logic [TICKET_W-1:0] mod_val;
  logic [WORKER_W-1:0] rem;
  logic [2:0]          idx;
  tcld_job_t           job;

  logic [COUNT_W-1:0]  cnt_eff;
  logic                warmup;
  logic [COUNT_W-1:0]  rr_diff;
  logic [WORKER_W-1:0] rr_first;
  logic [WORKER_W-1:0] rem_next;

  always_comb begin
    if (worker_count == '0) begin
      cnt_eff = COUNT_W'(1);
    end else if (worker_count > MAX_CNT) begin
      cnt_eff = MAX_CNT;
    end else begin
      cnt_eff = worker_count;
    end
    warmup   = (ticket_counter[TICKET_W-1:5] == '0) &&
               (ticket_counter[4:0] < {cnt_eff, 1'b0});
    rr_diff  = ticket_counter[3:0] - cnt_eff;
    rr_first = (ticket_counter[3:0] < cnt_eff) ? ticket_counter[2:0] : rr_diff[2:0];
    rem_next = mod_step8(rem, mod_val[{idx, 3'b000} +: 8], job.count);
  end

  assign in_ready   = (fstate == F_IDLE);
  assign push_valid = (fstate == F_PUSH);
  assign push_data  = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate         <= F_IDLE;
      worker_count   <= COUNT_W'(1);
      ticket_counter <= '0;
      running_seed   <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_WORKER_COUNT) begin
        worker_count <= cfg_data[COUNT_W-1:0];
      end
      if (cfg_we && cfg_index == REG_INITIAL_SEED) begin
        running_seed <= cfg_data;
      end
      unique case (fstate)
        F_IDLE: begin
          if (in_valid) begin
            job.loads <= in_loads;
            job.count <= cnt_eff;
            job.hash  <= ticket_counter ^ running_seed;
            if (cnt_eff == COUNT_W'(1)) begin
              job.kind  <= KIND_SINGLE;
              job.first <= '0;
              fstate    <= F_PUSH;
            end else if (warmup) begin
              job.kind       <= KIND_ROUND;
              job.first      <= rr_first;
              ticket_counter <= ticket_counter + 1'b1;
              fstate         <= F_PUSH;
            end else begin
              job.kind       <= KIND_BALANCE;
              mod_val        <= ticket_counter;
              rem            <= '0;
              idx            <= 3'd7;
              ticket_counter <= ticket_counter + 1'b1;
              running_seed   <= running_seed + GOLDEN_STEP;
              fstate         <= F_MOD;
            end
          end
        end
        F_MOD: begin
          // ticket mod count, one byte per cycle from the top
          rem <= rem_next;
          idx <= idx - 1'b1;
          if (idx == 3'd0) begin
            job.first <= rem_next;
            fstate    <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            fstate <= F_IDLE;
          end
        end
        default: fstate <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/tcld_queue.sv =====
// Short register queue of classified requests between front and back.
// Depends on tcld_pkg.
module tcld_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  tcld_pkg::tcld_job_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output tcld_pkg::tcld_job_t pop_data
);
  import tcld_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL = FILL_W'(QUEUE_DEPTH);

  tcld_job_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != FULL);
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/tcld_back.sv =====
// Back end: for balanced requests hashes the second pick (splitmix64 finalizer
// on a shared 32x32 multiplier), reduces it mod count and compares loads; drives output.
// Depends on tcld_pkg.
module tcld_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  tcld_pkg::tcld_job_t          pop_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tcld_pkg::WORKER_W-1:0] out_chosen,
  output logic                         out_bal
);
  import tcld_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_MOD  = 3'd2;
  localparam logic [2:0] B_PICK = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]          bstate;
  tcld_job_t           job;
  logic [TICKET_W-1:0] v;
  logic [TICKET_W-1:0] acc;
  logic [63:0]         prod;
  logic [1:0]          mstep;
  logic                msel;
  logic [2:0]          idx;
  logic [WORKER_W-1:0] rem;
  logic [WORKER_W-1:0] res_chosen;
  logic                res_bal;

  logic [TICKET_W-1:0] k;
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [63:0]         mul_p;
  logic [TICKET_W-1:0] mix_sum;
  logic [TICKET_W-1:0] mix_next;
  logic [WORKER_W-1:0] rem_next;
  logic [COUNT_W-1:0]  rem_inc;
  logic [WORKER_W-1:0] second;
  logic [LOAD_W-1:0]   load_a;
  logic [LOAD_W-1:0]   load_b;

  always_comb begin
    k        = msel ? MIX_MUL_B : MIX_MUL_A;
    mul_a    = (mstep == 2'd1) ? v[63:32] : v[31:0];
    mul_b    = (mstep == 2'd2) ? k[63:32] : k[31:0];
    mul_p    = 64'(mul_a) * 64'(mul_b);
    mix_sum  = {acc[63:32] + prod[31:0], acc[31:0]};
    mix_next = msel ? (mix_sum ^ (mix_sum >> MIX_SHIFT_2))
                    : (mix_sum ^ (mix_sum >> MIX_SHIFT_1));
    rem_next = mod_step8(rem, v[{idx, 3'b000} +: 8], job.count);
    rem_inc  = {1'b0, rem} + 1'b1;
    // bump a colliding second pick to the next worker, wrapping at count
    if (rem != job.first) begin
      second = rem;
    end else if (rem_inc == job.count) begin
      second = '0;
    end else begin
      second = rem_inc[WORKER_W-1:0];
    end
    load_a = job.loads[job.first];
    load_b = job.loads[second];
  end

  assign pop_ready = (bstate == B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop the taken result unless a new one replaces it this cycle
      if (out_valid && out_ready && bstate != B_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (bstate)
        B_IDLE: begin
          if (pop_valid) begin
            job <= pop_data;
            if (pop_data.kind == KIND_BALANCE) begin
              v      <= pop_data.hash ^ (pop_data.hash >> MIX_SHIFT_0);
              mstep  <= 2'd0;
              msel   <= 1'b0;
              bstate <= B_MUL;
            end else begin
              res_chosen <= pop_data.first;
              res_bal    <= 1'b0;
              bstate     <= B_OUT;
            end
          end
        end
        B_MUL: begin
          // low 64 bits of v * k from three 32x32 partial products
          prod  <= mul_p;
          mstep <= mstep + 1'b1;
          if (mstep == 2'd1) begin
            acc <= prod;
          end else if (mstep == 2'd2) begin
            acc[63:32] <= acc[63:32] + prod[31:0];
          end else if (mstep == 2'd3) begin
            v <= mix_next;
            if (msel) begin
              rem    <= '0;
              idx    <= 3'd7;
              bstate <= B_MOD;
            end else begin
              msel <= 1'b1;
            end
          end
        end
        B_MOD: begin
          rem <= rem_next;
          idx <= idx - 1'b1;
          if (idx == 3'd0) begin
            bstate <= B_PICK;
          end
        end
        B_PICK: begin
          res_chosen <= (load_a <= load_b) ? job.first : second;
          res_bal    <= 1'b1;
          bstate     <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            out_chosen <= res_chosen;
            out_bal    <= res_bal;
            bstate     <= B_IDLE;
          end
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/two_choice_load_dispatcher_core.sv =====
// Two-choice load dispatcher, top level.
// Depends on tcld_pkg, tcld_front, tcld_queue and tcld_back.
//
// Each request on s_axis carries the load score of all eight workers; one
// result per request comes out on m_axis with the chosen worker index in
// tdata and, in tuser, a flag set when the two-choice load compare decided.
// cfg_we/cfg_index/cfg_data write worker_count (index 0) and initial_seed
// (index 1); a seed write also reloads the running seed. Write only while idle.
// The front takes a request when it is free: a single worker or a warm-up ticket
// goes straight to the push, a balanced request first works out the ticket mod
// count, one byte per cycle. A two-entry queue decouples it from the back, which
// for a balanced request runs two 64-bit multiplies on one shared 32x32
// multiplier, a mod count and a load compare. That back sequence sets the
// sustained rate of balanced requests; other requests pass the back through its
// idle and output states only. Reset clears ticket and seed, sets worker_count
// to 1 and empties the queue. A stalled m_axis holds its result in the output
// register while the back finishes the next one; further stalls back up through
// the queue into s_axis_tready.
module two_choice_load_dispatcher_core #(
  parameter int MAX_WORKERS = tcld_pkg::MAX_WORKERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tcld_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tcld_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // load_w0 [31:0], load_w1 [63:32], ... load_w7 [255:224]
  input  logic [255:0]                      s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // chosen_worker [2:0], zero fill [7:3]
  output logic [7:0]                        m_axis_tdata,
  // by_balance [0]
  output logic [0:0]                        m_axis_tuser
);
  import tcld_pkg::*;

  logic                push_valid;
  logic                push_ready;
  tcld_job_t           push_data;
  logic                pop_valid;
  logic                pop_ready;
  tcld_job_t           pop_data;
  logic [WORKER_W-1:0] out_chosen;
  logic                out_bal;

  tcld_front #(
    .MAX_WORKERS(MAX_WORKERS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_loads   (s_axis_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tcld_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tcld_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_chosen (out_chosen),
    .out_bal    (out_bal)
  );

  assign m_axis_tdata = {5'b00000, out_chosen};
  assign m_axis_tuser = out_bal;

endmodule
